/* hw/rtl/vfm_pkg.sv */
// ----------------------------------------------------------------------------
// vfm_pkg: shared types and tables of the voxel face mesher
// Operation codes, the vertex record and the per-face geometry tables.
// ----------------------------------------------------------------------------
package vfm_pkg;

  localparam int EdgeCellsDef = 32;
  localparam int CoordW       = 8;
  localparam int CountW       = 20;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_MESH  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [5:0]        x;
    logic [5:0]        y;
    logic [5:0]        z;
    logic [1:0]        u;
    logic [3:0]        v;
    logic [2:0]        kind;
    logic [2:0]        face;
    logic [1:0]        ao;
    logic [CountW-1:0] base;
  } vertex_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  function automatic logic signed [CoordW-1:0] sv(input logic signed [1:0] s);
    sv = CoordW'(s);
  endfunction

  function automatic vec_t mk(input logic signed [1:0] x, input logic signed [1:0] y,
                              input logic signed [1:0] z);
    mk.x = sv(x);
    mk.y = sv(y);
    mk.z = sv(z);
  endfunction

  // Neighbor offset across each face.
  function automatic vec_t face_nd(input logic [2:0] f);
    case (f)
      3'd0:    face_nd = mk(2'sd0, 2'sd1, 2'sd0);
      3'd1:    face_nd = mk(2'sd0, -2'sd1, 2'sd0);
      3'd2:    face_nd = mk(-2'sd1, 2'sd0, 2'sd0);
      3'd3:    face_nd = mk(2'sd1, 2'sd0, 2'sd0);
      3'd4:    face_nd = mk(2'sd0, 2'sd0, -2'sd1);
      default: face_nd = mk(2'sd0, 2'sd0, 2'sd1);
    endcase
  endfunction

  // In-plane left direction.
  function automatic vec_t face_lv(input logic [2:0] f);
    if (f == 3'd2 || f == 3'd3) face_lv = mk(2'sd0, 2'sd0, 2'sd1);
    else                        face_lv = mk(-2'sd1, 2'sd0, 2'sd0);
  endfunction

  // In-plane up direction.
  function automatic vec_t face_uv(input logic [2:0] f);
    if (f == 3'd0 || f == 3'd1) face_uv = mk(2'sd0, 2'sd0, 2'sd1);
    else                        face_uv = mk(2'sd0, 2'sd1, 2'sd0);
  endfunction

  function automatic logic [1:0] face_ubase(input logic [2:0] f);
    case (f)
      3'd0:    face_ubase = 2'd2;
      3'd1:    face_ubase = 2'd0;
      default: face_ubase = 2'd1;
    endcase
  endfunction

  // Corner code of vertex k: 0 top-left, 1 top-right, 2 bottom-right, 3 bottom-left.
  function automatic logic [1:0] face_corner(input logic [2:0] f, input logic [1:0] k);
    logic [7:0] row;
    case (f)
      3'd1:          row = {2'd1, 2'd2, 2'd3, 2'd0};
      3'd3, 3'd5:    row = {2'd3, 2'd0, 2'd1, 2'd2};
      default:       row = {2'd2, 2'd1, 2'd0, 2'd3};
    endcase
    face_corner = row[2*k +: 2];
  endfunction

  // Corner position offset {x,y,z} of vertex k.
  function automatic logic [2:0] face_off(input logic [2:0] f, input logic [1:0] k);
    logic [11:0] row;
    case (f)
      3'd0:    row = {3'b110, 3'b111, 3'b011, 3'b010};
      3'd1:    row = {3'b101, 3'b100, 3'b000, 3'b001};
      3'd2:    row = {3'b000, 3'b010, 3'b011, 3'b001};
      3'd3:    row = {3'b101, 3'b111, 3'b110, 3'b100};
      3'd4:    row = {3'b100, 3'b110, 3'b010, 3'b000};
      default: row = {3'b001, 3'b011, 3'b111, 3'b101};
    endcase
    face_off = row[3*k +: 3];
  endfunction

  // Read order over the 3x3 plane: the neighbor first, then its ring.
  // Result is {left index, up index}, each 0..2 for offsets -1..+1.
  function automatic logic [3:0] ring_pos(input logic [3:0] j);
    case (j)
      4'd0:    ring_pos = {2'd1, 2'd1};
      4'd1:    ring_pos = {2'd0, 2'd0};
      4'd2:    ring_pos = {2'd0, 2'd1};
      4'd3:    ring_pos = {2'd0, 2'd2};
      4'd4:    ring_pos = {2'd1, 2'd0};
      4'd5:    ring_pos = {2'd1, 2'd2};
      4'd6:    ring_pos = {2'd2, 2'd0};
      4'd7:    ring_pos = {2'd2, 2'd1};
      default: ring_pos = {2'd2, 2'd2};
    endcase
  endfunction

endpackage

/* hw/rtl/vfm_ram.sv */
// ----------------------------------------------------------------------------
// vfm_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module vfm_ram #(
  parameter int Width = 3,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/voxel_face_mesher_with_ao_core.sv */
// ----------------------------------------------------------------------------
// voxel_face_mesher_with_ao_core: voxel face mesher with ambient occlusion
// Culls hidden faces of one voxel and emits its quad vertices with AO counts.
// ----------------------------------------------------------------------------
// Usage. An item is taken at a rising edge with start high and busy low.
// Operation clear sets the running vertex base to zero, and load writes one
// cell of the bordered grid; both finish in the accepting cycle and leave
// busy low. A mesh item names an interior voxel. The core reads the voxel,
// then for each of the six faces reads the neighbor and, if it is empty, the
// eight cells of the plane around it from the single grid RAM port, one read
// a cycle. Each visible face gives four vertices on result_valid_o, each
// valid for exactly one cycle; last_o marks the final vertex of the item.
// Because last is only known once all faces are checked, each vertex is held
// in a hold register before it leaves.
// An item ends when busy falls again: clear, load and an out-of-range mesh end
// in the accepting cycle and an empty voxel after its voxel read. Otherwise the
// core checks the faces in turn, a hidden face by its neighbor alone and a
// visible one by the whole plane and its four vertices, then takes the
// finishing step and, when any face is visible, shows the final vertex.
// Reset clears the control state and the vertex base; the grid is undefined
// until loaded. The receiver cannot stall the results.
// ----------------------------------------------------------------------------
module voxel_face_mesher_with_ao_core #(
  parameter int EDGE_CELLS = vfm_pkg::EdgeCellsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic [5:0]  cell_z_i,
  input  logic [2:0]  cell_kind_i,
  output logic        result_valid_o,
  output logic [5:0]  vert_x_o,
  output logic [5:0]  vert_y_o,
  output logic [5:0]  vert_z_o,
  output logic [1:0]  tex_u_o,
  output logic [3:0]  tex_v_o,
  output logic [2:0]  vert_kind_o,
  output logic [2:0]  face_id_o,
  output logic [1:0]  occlusion_o,
  output logic [19:0] face_base_o,
  output logic        last_o
);
  import vfm_pkg::*;

  localparam int Side  = EDGE_CELLS + 2;
  localparam int Depth = Side * Side * Side;
  localparam int AW    = $clog2(Depth);
  localparam logic [AW-1:0] SideA  = AW'(Side);
  localparam logic [AW-1:0] PlaneA = AW'(Side * Side);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CHK  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [CoordW-1:0] cx_q, cy_q, cz_q;
  logic [2:0]        kind_q;
  logic [2:0]        face_q;
  logic [3:0]        ridx_q;
  logic [1:0]        k_q;
  logic              pend_q;
  logic [3:0]        ppos_q;
  logic              prange_q;
  logic [8:0]        emp_q;
  logic [CountW-1:0] count_q;
  vertex_t           hold_q;
  logic              hold_v_q;
  vertex_t           out_q;
  logic              out_v_q, out_last_q;

  logic accept;
  assign accept = start && !busy;

  // Address of a cell; the caller guarantees the coordinate lies in the grid.
  function automatic logic [AW-1:0] cell_addr(input logic signed [CoordW-1:0] x,
                                               input logic signed [CoordW-1:0] y,
                                               input logic signed [CoordW-1:0] z);
    cell_addr = AW'(x[CoordW-1:0]) + AW'(z[CoordW-1:0]) * SideA
              + AW'(y[CoordW-1:0]) * PlaneA;
  endfunction

  function automatic logic in_grid(input logic signed [CoordW-1:0] c);
    in_grid = (c >= 0) && (c < CoordW'(Side));
  endfunction

  // Offset along an in-plane axis for a ring index of 0, 1 or 2.
  function automatic logic signed [CoordW-1:0] step(input logic [1:0] idx,
                                                    input logic signed [CoordW-1:0] c);
    case (idx)
      2'd0:    step = -c;
      2'd2:    step = c;
      default: step = '0;
    endcase
  endfunction

  // Coordinates of the current plane read.
  vec_t nd, lv, uv;
  logic [3:0] rpos;
  logic signed [CoordW-1:0] px, py, pz;
  logic prange;

  always_comb begin
    nd   = face_nd(face_q);
    lv   = face_lv(face_q);
    uv   = face_uv(face_q);
    rpos = ring_pos(ridx_q);
    px = cx_q + nd.x + step(rpos[3:2], lv.x) + step(rpos[1:0], uv.x);
    py = cy_q + nd.y + step(rpos[3:2], lv.y) + step(rpos[1:0], uv.y);
    pz = cz_q + nd.z + step(rpos[3:2], lv.z) + step(rpos[1:0], uv.z);
    prange = in_grid(px) && in_grid(py) && in_grid(pz);
  end

  // Grid RAM port: loads write in the accepting cycle, mesh reads elsewhere.
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [2:0]        ram_rdata;
  logic signed [CoordW-1:0] ix, iy, iz;
  logic load_ok, mesh_ok;

  always_comb begin
    ix = CoordW'(cell_x_i);
    iy = CoordW'(cell_y_i);
    iz = CoordW'(cell_z_i);
    load_ok = in_grid(ix) && in_grid(iy) && in_grid(iz);
    mesh_ok = (ix >= 1) && (ix <= CoordW'(EDGE_CELLS)) && (iy >= 1)
           && (iy <= CoordW'(EDGE_CELLS)) && (iz >= 1) && (iz <= CoordW'(EDGE_CELLS));
    ram_we   = accept && (operation_i == OP_LOAD) && load_ok;
    if (state_q == ST_RD) ram_addr = cell_addr(px, py, pz);
    else                  ram_addr = cell_addr(ix, iy, iz);
  end

  vfm_ram #(.Width(3), .Depth(Depth)) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (cell_kind_i),
    .rdata_o (ram_rdata)
  );

  // Vertex built from the current face, corner and captured plane.
  vertex_t vtx;
  logic [1:0] corner, ai, bi;
  logic [2:0] off;

  always_comb begin
    corner = face_corner(face_q, k_q);
    off    = face_off(face_q, k_q);
    ai     = (corner == 2'd0 || corner == 2'd3) ? 2'd2 : 2'd0;
    bi     = (corner == 2'd0 || corner == 2'd1) ? 2'd2 : 2'd0;
    vtx.x    = cx_q[5:0] - 6'd1 + 6'(off[2]);
    vtx.y    = cy_q[5:0] - 6'd1 + 6'(off[1]);
    vtx.z    = cz_q[5:0] - 6'd1 + 6'(off[0]);
    vtx.u    = face_ubase(face_q) + 2'((corner == 2'd0 || corner == 2'd3) ? 1 : 0);
    vtx.v    = 4'(kind_q) + 4'((corner == 2'd2 || corner == 2'd3) ? 1 : 0);
    vtx.kind = kind_q;
    vtx.face = face_q;
    vtx.ao   = 2'(emp_q[4'(ai) * 4'd3 + 4'd1]) + 2'(emp_q[4'(ai) * 4'd3 + 4'(bi)])
             + 2'(emp_q[4'd3 + 4'(bi)]);
    vtx.base = count_q;
  end

  logic cap_empty;
  assign cap_empty = prange_q && (ram_rdata == 3'd0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && operation_i == OP_MESH && mesh_ok) state_d = ST_CHK;
      ST_CHK:  state_d = (ram_rdata == 3'd0) ? ST_IDLE : ST_RD;
      ST_RD: begin
        if (pend_q && ppos_q == 4'd4 && !cap_empty) begin
          state_d = (face_q == 3'd5) ? ST_FIN : ST_RD;
        end else if (pend_q && ppos_q == 4'd8) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: if (k_q == 2'd3) state_d = (face_q == 3'd5) ? ST_FIN : ST_RD;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      pend_q   <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= 1'b0;
      pend_q  <= 1'b0;
      if (accept && operation_i == OP_CLEAR) count_q <= '0;
      case (state_q)
        ST_RD: begin
          pend_q <= (ridx_q < 4'd9);
          if (pend_q && ppos_q == 4'd4 && !cap_empty) pend_q <= 1'b0;
        end
        ST_EMIT: begin
          if (hold_v_q) out_v_q <= 1'b1;
          hold_v_q <= 1'b1;
          if (k_q == 2'd3) count_q <= count_q + CountW'(4);
        end
        ST_FIN: begin
          out_v_q  <= hold_v_q;
          hold_v_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload and sequencing registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cx_q <= ix;
        cy_q <= iy;
        cz_q <= iz;
      end
      ST_CHK: begin
        kind_q <= ram_rdata;
        face_q <= 3'd0;
        ridx_q <= 4'd0;
      end
      ST_RD: begin
        if (ridx_q < 4'd9) ridx_q <= ridx_q + 4'd1;
        ppos_q   <= 4'(rpos[3:2]) * 4'd3 + 4'(rpos[1:0]);
        prange_q <= prange;
        if (pend_q) emp_q[ppos_q] <= cap_empty;
        if (pend_q && ppos_q == 4'd4 && !cap_empty) begin
          face_q <= face_q + 3'd1;
          ridx_q <= 4'd0;
        end
        k_q <= 2'd0;
      end
      ST_EMIT: begin
        k_q    <= k_q + 2'd1;
        hold_q <= vtx;
        if (hold_v_q) begin
          out_q      <= hold_q;
          out_last_q <= 1'b0;
        end
        if (k_q == 2'd3) begin
          face_q <= face_q + 3'd1;
          ridx_q <= 4'd0;
        end
      end
      ST_FIN: begin
        out_q      <= hold_q;
        out_last_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign busy           = (state_q != ST_IDLE) || out_v_q;
  assign result_valid_o = out_v_q;
  assign vert_x_o       = out_q.x;
  assign vert_y_o       = out_q.y;
  assign vert_z_o       = out_q.z;
  assign tex_u_o        = out_q.u;
  assign tex_v_o        = out_q.v;
  assign vert_kind_o    = out_q.kind;
  assign face_id_o      = out_q.face;
  assign occlusion_o    = out_q.ao;
  assign face_base_o    = out_q.base;
  assign last_o         = out_last_q;

endmodule

/* hw/rtl/vfm_checker.sv */
// ----------------------------------------------------------------------------
// vfm_checker: port-level checks of the voxel face mesher
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module vfm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  operation_i,
  input logic        result_valid_o,
  input logic [3:0]  tex_v_o,
  input logic [2:0]  vert_kind_o,
  input logic [2:0]  face_id_o,
  input logic        last_o
);
  import vfm_pkg::*;

  // A vertex only leaves while the core reports itself busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) result_valid_o |-> busy)
    else $error("vertex shown while idle");

  // The final vertex of an item is never followed directly by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("vertex right after last");

  // Clear and load items give no vertices.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && operation_i != OP_MESH |=> !result_valid_o)
    else $error("vertex after a non-mesh item");

  // Texture v is the kind, or the kind plus one, and the face code is valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (face_id_o <= 3'd5) && ((tex_v_o == {1'b0, vert_kind_o})
                       || (tex_v_o == {1'b0, vert_kind_o} + 4'd1)))
    else $error("malformed vertex");

endmodule

bind voxel_face_mesher_with_ao_core vfm_checker u_vfm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .operation_i    (operation_i),
  .result_valid_o (result_valid_o),
  .tex_v_o        (tex_v_o),
  .vert_kind_o    (vert_kind_o),
  .face_id_o      (face_id_o),
  .last_o         (last_o)
);
